// ===== sv/ray_triangle_closest_hit_defines.svh =====
// Assertion macros shared by the closest-hit search block.
`ifndef RAY_TRIANGLE_CLOSEST_HIT_DEFINES_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RTCH_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtch assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define RTCH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtch assertion failed: next-cycle implication");

`endif

// ===== sv/rtch_pkg.sv =====
`timescale 1ns / 1ps

package rtch_pkg;

  localparam logic CMD_RAY = 1'b0;
  localparam logic CMD_TRI = 1'b1;

  localparam logic [30:0] NO_HIT_T  = 31'h7FFF_FFFF;
  localparam logic [30:0] MAX_HIT_T = 31'h7FFF_FFFE;
  localparam logic [30:0] Q_SAT     = 31'h7FFF_FFFF;
  localparam logic [16:0] MIN_DIST_RESET = 17'd655;
  localparam logic signed [32:0] ONE_Q16 = 33'sd65536;
  localparam int NUM_OPS = 24;

  typedef enum logic [3:0] {
    A_E1Y, A_E2Y, A_WVY, A_DVY, A_M1, A_M2, A_M3, A_M4, A_M5, A_M6
  } a_sel_t;

  typedef enum logic [2:0] {
    B_E1X, B_E2X, B_WVX, B_DVX, B_E1Z, B_E2Z, B_WVZ, B_DVZ
  } b_sel_t;

  typedef enum logic [3:0] {
    D_M1, D_M2, D_M3, D_M4, D_M5, D_M6, D_DEN, D_NB, D_NG, D_NT
  } dest_t;

  typedef struct packed {
    a_sel_t a;
    b_sel_t b;
    logic   neg;
    logic   first;
    dest_t  dest;
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_DIV_SETUP, S_DIV, S_EVAL, S_FINISH
  } state_t;

  // Multiply-accumulate program for the Cramer's rule determinants.
  function automatic op_t op_rom(input logic [4:0] idx);
    op_t o;
    case (idx)
      5'd0:  o = '{A_E2Y, B_DVZ, 1'b0, 1'b1, D_M1};
      5'd1:  o = '{A_DVY, B_E2Z, 1'b1, 1'b0, D_M1};
      5'd2:  o = '{A_WVY, B_DVZ, 1'b0, 1'b1, D_M2};
      5'd3:  o = '{A_DVY, B_WVZ, 1'b1, 1'b0, D_M2};
      5'd4:  o = '{A_E2Y, B_WVZ, 1'b0, 1'b1, D_M3};
      5'd5:  o = '{A_WVY, B_E2Z, 1'b1, 1'b0, D_M3};
      5'd6:  o = '{A_DVY, B_E1Z, 1'b0, 1'b1, D_M4};
      5'd7:  o = '{A_E1Y, B_DVZ, 1'b1, 1'b0, D_M4};
      5'd8:  o = '{A_E1Y, B_E2Z, 1'b0, 1'b1, D_M5};
      5'd9:  o = '{A_E2Y, B_E1Z, 1'b1, 1'b0, D_M5};
      5'd10: o = '{A_E1Y, B_WVZ, 1'b0, 1'b1, D_M6};
      5'd11: o = '{A_WVY, B_E1Z, 1'b1, 1'b0, D_M6};
      5'd12: o = '{A_M1,  B_E1X, 1'b0, 1'b1, D_DEN};
      5'd13: o = '{A_M4,  B_E2X, 1'b0, 1'b0, D_DEN};
      5'd14: o = '{A_M5,  B_DVX, 1'b0, 1'b0, D_DEN};
      5'd15: o = '{A_M1,  B_WVX, 1'b0, 1'b1, D_NB};
      5'd16: o = '{A_M2,  B_E2X, 1'b1, 1'b0, D_NB};
      5'd17: o = '{A_M3,  B_DVX, 1'b1, 1'b0, D_NB};
      5'd18: o = '{A_M2,  B_E1X, 1'b0, 1'b1, D_NG};
      5'd19: o = '{A_M4,  B_WVX, 1'b0, 1'b0, D_NG};
      5'd20: o = '{A_M6,  B_DVX, 1'b0, 1'b0, D_NG};
      5'd21: o = '{A_M3,  B_E1X, 1'b0, 1'b1, D_NT};
      5'd22: o = '{A_M6,  B_E2X, 1'b1, 1'b0, D_NT};
      5'd23: o = '{A_M5,  B_WVX, 1'b0, 1'b0, D_NT};
      default: o = '{A_E1Y, B_E1X, 1'b0, 1'b1, D_M1};
    endcase
    return o;
  endfunction

endpackage

// ===== sv/ray_triangle_closest_hit.sv =====
// Closest-hit search of one ray over a stream of triangles.
// Input channel (in_valid/in_ready): one beat is either a ray (command 0,
// origin on p0, direction on p1) or one triangle (command 1, vertices on
// p0..p2, tri_id). A beat with last set closes the search and produces one
// result beat on the output channel (out_valid/out_ready): hit, hit_id, hit_t.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes min_distance
// and is always ready; the user must write it only while the block is idle,
// which the block does not enforce. The front stage forms edge vectors against
// its own copy of the ray and pushes each beat into a two-entry queue, so up
// to two beats are taken while the back end is busy. The back end runs the
// Cramer's rule determinants on a single shift-add multiplier, one multiplier
// bit per cycle over 24 products, then three restoring divisions of up to 32
// steps each unless the determinant is zero. The result of the last beat is
// loaded into an output register in the finish state and held there while
// the receiver stalls; the back end waits only if a second result is ready
// before the first is taken.
// Reset clears the ray to zero, the best hit to no-hit, min_distance to 655
// and empties the queue and the output register.
`timescale 1ns / 1ps

module ray_triangle_closest_hit #(
  parameter int COORD_BITS = 32,
  parameter int ID_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic command,
  input  logic signed [COORD_BITS-1:0] p0_x,
  input  logic signed [COORD_BITS-1:0] p0_y,
  input  logic signed [COORD_BITS-1:0] p0_z,
  input  logic signed [COORD_BITS-1:0] p1_x,
  input  logic signed [COORD_BITS-1:0] p1_y,
  input  logic signed [COORD_BITS-1:0] p1_z,
  input  logic signed [COORD_BITS-1:0] p2_x,
  input  logic signed [COORD_BITS-1:0] p2_y,
  input  logic signed [COORD_BITS-1:0] p2_z,
  input  logic [ID_BITS-1:0] tri_id,
  input  logic last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [16:0] cfg_data,
  output logic out_valid,
  input  logic out_ready,
  output logic hit,
  output logic [ID_BITS-1:0] hit_id,
  output logic [30:0] hit_t
);

  localparam int EW = 2 + ID_BITS + 12 * (COORD_BITS + 1);

  logic push_valid, push_ready;
  logic [EW-1:0] push_data;
  logic q_valid, q_ready;
  logic [EW-1:0] q_data;

  // The register port never stalls.
  assign cfg_ready = 1'b1;

  rtch_front #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
    .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
    .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
    .tri_id(tri_id), .last(last),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  rtch_queue #(.WIDTH(EW)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(push_valid), .in_ready(push_ready), .in_data(push_data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  rtch_back #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .hit_id(hit_id), .hit_t(hit_t)
  );

endmodule

// ===== sv/rtch_front.sv =====
`timescale 1ns / 1ps

module rtch_front #(
  parameter int COORD_BITS = 32,
  parameter int ID_BITS = 16,
  localparam int W = COORD_BITS + 1,
  localparam int EW = 2 + ID_BITS + 12 * W
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic command,
  input  logic signed [COORD_BITS-1:0] p0_x,
  input  logic signed [COORD_BITS-1:0] p0_y,
  input  logic signed [COORD_BITS-1:0] p0_z,
  input  logic signed [COORD_BITS-1:0] p1_x,
  input  logic signed [COORD_BITS-1:0] p1_y,
  input  logic signed [COORD_BITS-1:0] p1_z,
  input  logic signed [COORD_BITS-1:0] p2_x,
  input  logic signed [COORD_BITS-1:0] p2_y,
  input  logic signed [COORD_BITS-1:0] p2_z,
  input  logic [ID_BITS-1:0] tri_id,
  input  logic last,
  output logic push_valid,
  input  logic push_ready,
  output logic [EW-1:0] push_data
);

  logic signed [COORD_BITS-1:0] org [3];
  logic signed [COORD_BITS-1:0] dir [3];
  logic signed [W-1:0] e1 [3];
  logic signed [W-1:0] e2 [3];
  logic signed [W-1:0] wv [3];
  logic signed [W-1:0] dv [3];
  logic signed [COORD_BITS-1:0] v0 [3];
  logic signed [COORD_BITS-1:0] v1 [3];
  logic signed [COORD_BITS-1:0] v2 [3];

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  assign v0[0] = p0_x;
  assign v0[1] = p0_y;
  assign v0[2] = p0_z;
  assign v1[0] = p1_x;
  assign v1[1] = p1_y;
  assign v1[2] = p1_z;
  assign v2[0] = p2_x;
  assign v2[1] = p2_y;
  assign v2[2] = p2_z;

  // Edge vectors and origin offset, one bit wider than a coordinate.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = W'(v0[k]) - W'(v1[k]);
      e2[k] = W'(v0[k]) - W'(v2[k]);
      wv[k] = W'(v0[k]) - W'(org[k]);
      dv[k] = W'(dir[k]);
    end
  end

  assign push_data = {command, last, tri_id,
                      dv[2], dv[1], dv[0], wv[2], wv[1], wv[0],
                      e2[2], e2[1], e2[0], e1[2], e1[1], e1[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        org[k] <= '0;
        dir[k] <= '0;
      end
    end else if (in_valid && in_ready && command == rtch_pkg::CMD_RAY) begin
      for (int k = 0; k < 3; k++) begin
        org[k] <= v0[k];
        dir[k] <= v1[k];
      end
    end
  end

endmodule

// ===== sv/rtch_queue.sv =====
`timescale 1ns / 1ps

module rtch_queue #(
  parameter int WIDTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic out_valid,
  input  logic out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slot [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push;
  logic pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/rtch_back.sv =====
`timescale 1ns / 1ps
`include "ray_triangle_closest_hit_defines.svh"

module rtch_back #(
  parameter int COORD_BITS = 32,
  parameter int ID_BITS = 16,
  localparam int W = COORD_BITS + 1,
  localparam int EW = 2 + ID_BITS + 12 * W
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  logic [EW-1:0] q_data,
  input  logic cfg_we,
  input  logic [16:0] cfg_data,
  output logic out_valid,
  input  logic out_ready,
  output logic hit,
  output logic [ID_BITS-1:0] hit_id,
  output logic [30:0] hit_t
);

  localparam int MW  = 2 * W + 1;
  localparam int ACC = 3 * W + 4;
  localparam int DW  = ACC + 32;
  localparam int BCW = $clog2(W);

  rtch_pkg::state_t state, state_next;
  rtch_pkg::op_t op;

  logic [EW-1:0] item;
  logic item_last;
  logic [ID_BITS-1:0] item_id;

  logic [16:0] min_distance;
  logic [30:0] best_distance;
  logic [ID_BITS-1:0] best_id;
  logic have_hit;

  logic [4:0] op_idx;
  logic [BCW-1:0] bcnt;
  logic signed [ACC-1:0] acc;
  logic signed [ACC-1:0] a_sh;
  logic [W-1:0] b_sh;
  logic signed [ACC-1:0] a_val;
  logic [W-1:0] b_val;
  logic signed [ACC-1:0] addend;
  logic signed [ACC-1:0] acc_new;
  logic mul_last;

  logic signed [MW-1:0] m [6];
  logic signed [ACC-1:0] den, nb, ng, nt;

  logic [1:0] div_idx;
  logic [4:0] dcnt;
  logic [DW-1:0] n_rem;
  logic [DW-1:0] d_sh;
  logic [29:0] q;
  logic q_neg;
  logic ge;
  logic div_done;
  logic [30:0] q_fin;
  logic signed [31:0] q_res;
  logic signed [ACC-1:0] num_sel;
  logic [ACC-1:0] num_abs;
  logic [ACC-1:0] den_abs;
  logic den_zero;

  logic signed [31:0] beta, gamma, tq;
  logic signed [32:0] bg_sum;
  logic tri_hit;
  logic [30:0] ts;

  logic out_free;
  logic out_load;

  function automatic logic signed [W-1:0] crd(input logic [EW-1:0] v, input int k);
    return v[k*W +: W];
  endfunction

  assign item_last = item[EW-2];
  assign item_id   = item[12*W +: ID_BITS];
  assign op        = rtch_pkg::op_rom(op_idx);

  // Operand selection for the shift-add multiplier.
  always_comb begin
    case (op.a)
      rtch_pkg::A_E1Y: a_val = ACC'(crd(item, 1));
      rtch_pkg::A_E2Y: a_val = ACC'(crd(item, 4));
      rtch_pkg::A_WVY: a_val = ACC'(crd(item, 7));
      rtch_pkg::A_DVY: a_val = ACC'(crd(item, 10));
      rtch_pkg::A_M1:  a_val = ACC'(m[0]);
      rtch_pkg::A_M2:  a_val = ACC'(m[1]);
      rtch_pkg::A_M3:  a_val = ACC'(m[2]);
      rtch_pkg::A_M4:  a_val = ACC'(m[3]);
      rtch_pkg::A_M5:  a_val = ACC'(m[4]);
      rtch_pkg::A_M6:  a_val = ACC'(m[5]);
      default:         a_val = '0;
    endcase
    case (op.b)
      rtch_pkg::B_E1X: b_val = crd(item, 0);
      rtch_pkg::B_E2X: b_val = crd(item, 3);
      rtch_pkg::B_WVX: b_val = crd(item, 6);
      rtch_pkg::B_DVX: b_val = crd(item, 9);
      rtch_pkg::B_E1Z: b_val = crd(item, 2);
      rtch_pkg::B_E2Z: b_val = crd(item, 5);
      rtch_pkg::B_WVZ: b_val = crd(item, 8);
      rtch_pkg::B_DVZ: b_val = crd(item, 11);
      default:         b_val = '0;
    endcase
  end

  // One multiplier bit per cycle; the sign bit of b carries negative weight.
  always_comb begin
    mul_last = (bcnt == BCW'(W - 1));
    addend   = b_sh[0] ? a_sh : '0;
    acc_new  = (op.neg ^ mul_last) ? (acc - addend) : (acc + addend);
  end

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    case (div_idx)
      2'd0:    num_sel = nb;
      2'd1:    num_sel = ng;
      default: num_sel = nt;
    endcase
    num_abs  = num_sel[ACC-1] ? ACC'(-num_sel) : ACC'(num_sel);
    den_abs  = den[ACC-1] ? ACC'(-den) : ACC'(den);
    den_zero = (den == '0);
    ge       = (n_rem >= d_sh);
    div_done = 1'b0;
    q_fin    = {q, ge};
    if (state == rtch_pkg::S_DIV) begin
      if (dcnt == 5'd31) begin
        div_done = ge;
        q_fin    = rtch_pkg::Q_SAT;
      end else begin
        div_done = (dcnt == 5'd0);
      end
    end
    q_res = q_neg ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
  end

  // Hit test on the three quotients.
  always_comb begin
    bg_sum  = 33'(beta) + 33'(gamma);
    tri_hit = !beta[31] && !gamma[31] && (bg_sum <= rtch_pkg::ONE_Q16)
              && (tq >= $signed({15'd0, min_distance}));
    ts = (tq > $signed({1'b0, rtch_pkg::MAX_HIT_T})) ? rtch_pkg::MAX_HIT_T : tq[30:0];
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      rtch_pkg::S_IDLE: begin
        if (q_valid) begin
          state_next = (q_data[EW-1] == rtch_pkg::CMD_RAY) ? rtch_pkg::S_FINISH
                                                            : rtch_pkg::S_LOAD;
        end
      end
      rtch_pkg::S_LOAD: state_next = rtch_pkg::S_MUL;
      rtch_pkg::S_MUL: begin
        if (mul_last) begin
          state_next = (op_idx == 5'(rtch_pkg::NUM_OPS - 1)) ? rtch_pkg::S_DIV_SETUP
                                                              : rtch_pkg::S_LOAD;
        end
      end
      rtch_pkg::S_DIV_SETUP: begin
        state_next = den_zero ? rtch_pkg::S_FINISH : rtch_pkg::S_DIV;
      end
      rtch_pkg::S_DIV: begin
        if (div_done) begin
          state_next = (div_idx == 2'd2) ? rtch_pkg::S_EVAL : rtch_pkg::S_DIV_SETUP;
        end
      end
      rtch_pkg::S_EVAL: state_next = rtch_pkg::S_FINISH;
      rtch_pkg::S_FINISH: begin
        if (!item_last || out_free) begin
          state_next = rtch_pkg::S_IDLE;
        end
      end
      default: state_next = rtch_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_ready  = (state == rtch_pkg::S_IDLE);
    out_load = (state == rtch_pkg::S_FINISH) && item_last && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtch_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      rtch_pkg::S_IDLE: begin
        if (q_valid) begin
          item   <= q_data;
          op_idx <= '0;
        end
      end
      rtch_pkg::S_LOAD: begin
        a_sh <= a_val;
        b_sh <= b_val;
        bcnt <= '0;
        if (op.first) begin
          acc <= '0;
        end
      end
      rtch_pkg::S_MUL: begin
        acc  <= acc_new;
        a_sh <= a_sh <<< 1;
        b_sh <= b_sh >> 1;
        bcnt <= bcnt + 1'b1;
        if (mul_last) begin
          op_idx  <= op_idx + 5'd1;
          div_idx <= 2'd0;
          case (op.dest)
            rtch_pkg::D_M1:  m[0] <= acc_new[MW-1:0];
            rtch_pkg::D_M2:  m[1] <= acc_new[MW-1:0];
            rtch_pkg::D_M3:  m[2] <= acc_new[MW-1:0];
            rtch_pkg::D_M4:  m[3] <= acc_new[MW-1:0];
            rtch_pkg::D_M5:  m[4] <= acc_new[MW-1:0];
            rtch_pkg::D_M6:  m[5] <= acc_new[MW-1:0];
            rtch_pkg::D_DEN: den  <= acc_new;
            rtch_pkg::D_NB:  nb   <= acc_new;
            rtch_pkg::D_NG:  ng   <= acc_new;
            rtch_pkg::D_NT:  nt   <= acc_new;
            default:         den  <= den;
          endcase
        end
      end
      rtch_pkg::S_DIV_SETUP: begin
        n_rem <= DW'(num_abs) << 16;
        d_sh  <= DW'(den_abs) << 31;
        q_neg <= num_sel[ACC-1] ^ den[ACC-1];
        dcnt  <= 5'd31;
        q     <= '0;
      end
      rtch_pkg::S_DIV: begin
        d_sh <= d_sh >> 1;
        dcnt <= dcnt - 5'd1;
        if (dcnt != 5'd31) begin
          q <= {q[28:0], ge};
          if (ge) begin
            n_rem <= n_rem - d_sh;
          end
        end
        if (div_done) begin
          div_idx <= div_idx + 2'd1;
          case (div_idx)
            2'd0:    beta  <= q_res;
            2'd1:    gamma <= q_res;
            default: tq    <= q_res;
          endcase
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // Running best hit, configuration and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance  <= rtch_pkg::MIN_DIST_RESET;
      best_distance <= rtch_pkg::NO_HIT_T;
      best_id       <= '0;
      have_hit      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_distance <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == rtch_pkg::S_IDLE && q_valid && q_data[EW-1] == rtch_pkg::CMD_RAY) begin
        best_distance <= rtch_pkg::NO_HIT_T;
        best_id       <= '0;
        have_hit      <= 1'b0;
      end
      if (state == rtch_pkg::S_EVAL && tri_hit && ts < best_distance) begin
        best_distance <= ts;
        best_id       <= item_id;
        have_hit      <= 1'b1;
      end
      if (out_load) begin
        best_distance <= rtch_pkg::NO_HIT_T;
        best_id       <= '0;
        have_hit      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit    <= have_hit;
      hit_id <= have_hit ? best_id : '0;
      hit_t  <= have_hit ? best_distance : rtch_pkg::NO_HIT_T;
    end
  end

  `RTCH_ASSERT_IMPL(a_nohit_dist, clk, rst, !have_hit, best_distance == rtch_pkg::NO_HIT_T)
  `RTCH_ASSERT_IMPL(a_hit_t_valid, clk, rst, out_valid && hit, hit_t != rtch_pkg::NO_HIT_T)
  `RTCH_ASSERT_NEXT(a_finish_wait, clk, rst, state == rtch_pkg::S_FINISH && item_last && !out_free, state == rtch_pkg::S_FINISH)
  `RTCH_ASSERT_IMPL(a_op_range, clk, rst, state == rtch_pkg::S_MUL, op_idx < 5'(rtch_pkg::NUM_OPS))

endmodule

// ===== sim/ray_triangle_closest_hit_test.sv =====
`timescale 1ns / 1ps

// Checks the closest-hit search block against a predictor of its own.
module ray_triangle_closest_hit_test;

  localparam int ONE = 65536;
  localparam int CMIN = 32'sh8000_0000;
  localparam int CMAX = 32'sh7FFF_FFFF;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT = 3000;

  typedef logic signed [255:0] wide_t;

  // One input beat, optionally with a result typed in by hand.
  typedef struct {
    logic command;
    logic signed [31:0] c[9];
    logic [15:0] id;
    logic last;
    logic typed;
    logic e_hit;
    logic [15:0] e_id;
    logic [30:0] e_t;
  } beat_t;

  typedef struct {
    logic hit;
    logic [15:0] id;
    logic [30:0] t;
  } hit_rec_t;

  logic clk, rst;
  logic in_valid, in_ready, command, last;
  logic signed [31:0] p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
  logic [15:0] tri_id;
  logic cfg_valid, cfg_ready;
  logic [16:0] cfg_data;
  logic out_valid, out_ready, hit;
  logic [15:0] hit_id;
  logic [30:0] hit_t;

  ray_triangle_closest_hit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
    .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
    .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
    .tri_id(tri_id), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .hit_id(hit_id), .hit_t(hit_t)
  );

  // Predictor state: the ray, the best hit so far and the distance floor.
  logic signed [31:0] ray_org[3];
  logic signed [31:0] ray_dir[3];
  logic [30:0] best_t;
  logic [15:0] best_id;
  logic best_valid;
  logic [16:0] floor_t;

  hit_rec_t pending_hits[$];
  beat_t cur_beat;
  int errors = 0;
  int quiet_cycles = 0;
  bit brisk = 0;
  bit hold_long = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Signed quotient num/den as Q16.16, truncated toward zero and saturated.
  function automatic longint cramer_quot(wide_t num, wide_t den);
    logic [255:0] n, d, q;
    logic neg;
    neg = num[255] ^ den[255];
    n = num[255] ? -num : num;
    d = den[255] ? -den : den;
    n = n << 16;
    if (n >= (d << 31)) q = 256'(rtch_pkg::Q_SAT);
    else q = n / d;
    return neg ? -longint'(q[31:0]) : longint'(q[31:0]);
  endfunction

  // Cramer's rule test of one triangle against the held ray; the nearest
  // accepted hit replaces the best one only when strictly closer.
  function automatic void trace_triangle(beat_t b);
    wide_t v0[3], e1[3], e2[3], dv[3], wv[3];
    wide_t m1, m2, m3, m4, m5, m6, den, nb, ng, nt;
    longint beta, gamma, t;
    logic [30:0] ts;
    for (int k = 0; k < 3; k++) begin
      v0[k] = b.c[k];
      e1[k] = v0[k] - wide_t'(b.c[3 + k]);
      e2[k] = v0[k] - wide_t'(b.c[6 + k]);
      dv[k] = ray_dir[k];
      wv[k] = v0[k] - wide_t'(ray_org[k]);
    end
    m1 = e2[1] * dv[2] - dv[1] * e2[2];
    m2 = wv[1] * dv[2] - dv[1] * wv[2];
    m3 = e2[1] * wv[2] - wv[1] * e2[2];
    m4 = dv[1] * e1[2] - e1[1] * dv[2];
    m5 = e1[1] * e2[2] - e2[1] * e1[2];
    m6 = e1[1] * wv[2] - wv[1] * e1[2];
    den = e1[0] * m1 + e2[0] * m4 + dv[0] * m5;
    if (den == 0) return;
    nb = wv[0] * m1 - e2[0] * m2 - dv[0] * m3;
    ng = e1[0] * m2 + wv[0] * m4 + dv[0] * m6;
    nt = e1[0] * m3 - e2[0] * m6 + wv[0] * m5;
    beta = cramer_quot(nb, den);
    gamma = cramer_quot(ng, den);
    t = cramer_quot(nt, den);
    if (beta < 0 || gamma < 0 || beta + gamma > ONE) return;
    if (t < longint'(floor_t)) return;
    ts = (t > longint'(rtch_pkg::MAX_HIT_T)) ? rtch_pkg::MAX_HIT_T : t[30:0];
    if (ts < best_t) begin
      best_t = ts;
      best_id = b.id;
      best_valid = 1;
    end
  endfunction

  // Applies one accepted beat; a beat with last set queues its result.
  function automatic void search_step(beat_t b);
    hit_rec_t r;
    if (b.command == rtch_pkg::CMD_RAY) begin
      for (int k = 0; k < 3; k++) begin
        ray_org[k] = b.c[k];
        ray_dir[k] = b.c[3 + k];
      end
      best_valid = 0;
      best_t = rtch_pkg::NO_HIT_T;
      best_id = 0;
    end else begin
      trace_triangle(b);
    end
    if (!b.last) return;
    r.hit = best_valid;
    r.id = best_valid ? best_id : 16'd0;
    r.t = best_valid ? best_t : rtch_pkg::NO_HIT_T;
    if (b.typed) begin
      r.hit = b.e_hit;
      r.id = b.e_id;
      r.t = b.e_t;
    end
    pending_hits.push_back(r);
    best_valid = 0;
    best_t = rtch_pkg::NO_HIT_T;
    best_id = 0;
  endfunction

  function automatic beat_t mk_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                   int x2, int y2, int z2, int id, bit lst);
    beat_t b;
    b.command = rtch_pkg::CMD_TRI;
    b.c = '{x0, y0, z0, x1, y1, z1, x2, y2, z2};
    b.id = id[15:0];
    b.last = lst;
    b.typed = 0;
    b.e_hit = 0;
    b.e_id = 0;
    b.e_t = rtch_pkg::NO_HIT_T;
    return b;
  endfunction

  function automatic beat_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz, bit lst);
    beat_t b;
    b = mk_tri(ox, oy, oz, dx, dy, dz, $urandom, $urandom, $urandom, $urandom, lst);
    b.command = rtch_pkg::CMD_RAY;
    return b;
  endfunction

  function automatic beat_t as_miss(beat_t b);
    b.typed = 1;
    return b;
  endfunction

  function automatic int spread(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // Input channel: optional idle gap, then hold the beat until it is taken.
  task automatic send_beat(beat_t b);
    int gap;
    gap = brisk ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    cur_beat = b;
    command = b.command;
    {p0_x, p0_y, p0_z} = {b.c[0], b.c[1], b.c[2]};
    {p1_x, p1_y, p1_z} = {b.c[3], b.c[4], b.c[5]};
    {p2_x, p2_y, p2_z} = {b.c[6], b.c[7], b.c[8]};
    tri_id = b.id;
    last = b.last;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Waits for every result, lets any trailing triangle finish, then writes
  // the distance floor.
  task automatic write_floor(logic [16:0] v);
    in_valid = 0;
    wait (pending_hits.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_data = v;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    floor_t = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Well-formed search: a ray that may close it, else a few triangles near
  // points on the ray, the last closing it. Some vertex sets are noise.
  task automatic send_search(output int sent);
    int o[3], d[3], p[3], v[9], n;
    longint s;
    beat_t b;
    for (int k = 0; k < 3; k++) begin
      o[k] = spread(8 * ONE);
      d[k] = spread(2 * ONE);
    end
    b = mk_ray(o[0], o[1], o[2], d[0], d[1], d[2], $urandom_range(0, 19) == 0);
    send_beat(b);
    sent = 1;
    if (b.last) return;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(ONE / 10, 4 * ONE);
      for (int k = 0; k < 3; k++) p[k] = o[k] + int'((longint'(d[k]) * s) >>> 16);
      for (int j = 0; j < 9; j++) v[j] = p[j % 3] + spread(3 * ONE / 2);
      if ($urandom_range(0, 9) == 0) for (int j = 0; j < 9; j++) v[j] = $urandom;
      send_beat(mk_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
                       $urandom, i == n - 1));
      sent++;
    end
  endtask

  // Result channel: random stall per beat unless brisk, one long hold when asked for.
  initial begin
    int n;
    out_ready = 0;
    @(negedge clk);
    wait (!rst);
    forever begin
      if (hold_long) begin
        hold_long = 0;
        out_ready = 0;
        repeat (4000) @(negedge clk);
      end else if (!brisk) begin
        n = $urandom_range(0, 16);
        if (n > 0) begin
          out_ready = 0;
          repeat (n) @(negedge clk);
        end
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Prediction on each accepted input beat; comparison on each result beat.
  always @(posedge clk) begin
    hit_rec_t e;
    if (!rst) begin
      if (in_valid && in_ready) search_step(cur_beat);
      if (out_valid && out_ready) begin
        if (pending_hits.size() == 0) begin
          $display("%0t: result with none expected: hit %0b id %0h t %0h",
                   $realtime, hit, hit_id, hit_t);
          errors++;
        end else begin
          e = pending_hits.pop_front();
          if (hit !== e.hit) begin
            $display("%0t: hit expected %0b actual %0b", $realtime, e.hit, hit);
            errors++;
          end
          if (hit_id !== e.id) begin
            $display("%0t: hit_id expected %0h actual %0h", $realtime, e.id, hit_id);
            errors++;
          end
          if (hit_t !== e.t) begin
            $display("%0t: hit_t expected %0h actual %0h", $realtime, e.t, hit_t);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: too long with no beat on any channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ray_triangle_closest_hit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    beat_t plan[$];
    beat_t b;
    logic [16:0] floors[4];
    int sent, total;
    rst = 1;
    in_valid = 0;
    command = rtch_pkg::CMD_RAY;
    {p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z} = '0;
    tri_id = 0;
    last = 0;
    cfg_valid = 0;
    cfg_data = 0;
    for (int k = 0; k < 3; k++) begin
      ray_org[k] = 0;
      ray_dir[k] = 0;
    end
    best_t = rtch_pkg::NO_HIT_T;
    best_id = 0;
    best_valid = 0;
    floor_t = rtch_pkg::MIN_DIST_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed part. With no ray loaded the direction is zero, so the
    // determinant vanishes and the first triangle must miss.
    plan.push_back(as_miss(mk_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 16'h1234, 1)));
    // A ray that closes its own search is an empty search.
    plan.push_back(as_miss(mk_ray(ONE, 2 * ONE, 3 * ONE, 0, ONE, 0, 1)));
    // Ray down +z; a hit at 5.0, a tie at 5.0 that must lose, a closer
    // hit at 2.0, one behind the origin and a degenerate one.
    plan.push_back(mk_ray(0, 0, 0, 0, 0, ONE, 0));
    plan.push_back(mk_tri(-ONE, -ONE, 5 * ONE, 4 * ONE, -ONE, 5 * ONE,
                          -ONE, 4 * ONE, 5 * ONE, 1, 0));
    plan.push_back(mk_tri(-ONE, -ONE, 5 * ONE, 4 * ONE, -ONE, 5 * ONE,
                          -ONE, 4 * ONE, 5 * ONE, 2, 0));
    plan.push_back(mk_tri(-ONE, -ONE, 2 * ONE, 4 * ONE, -ONE, 2 * ONE,
                          -ONE, 4 * ONE, 2 * ONE, 3, 0));
    plan.push_back(mk_tri(-ONE, -ONE, -3 * ONE, 4 * ONE, -ONE, -3 * ONE,
                          -ONE, 4 * ONE, -3 * ONE, 4, 0));
    plan.push_back(mk_tri(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 5, 1));
    // The ray is kept after a result; a hit closer than the floor misses.
    plan.push_back(as_miss(mk_tri(-ONE, -ONE, 328, 4 * ONE, -ONE, 328,
                                  -ONE, 4 * ONE, 328, 6, 1)));
    // A tiny direction drives t past the top of the range: it saturates.
    plan.push_back(mk_ray(0, 0, 0, 0, 0, 1, 0));
    b = mk_tri(-ONE, -ONE, 30000 * ONE, 4 * ONE, -ONE, 30000 * ONE,
               -ONE, 4 * ONE, 30000 * ONE, 16'hFFFF, 1);
    b.typed = 1;
    b.e_hit = 1;
    b.e_id = 16'hFFFF;
    b.e_t = rtch_pkg::MAX_HIT_T;
    plan.push_back(b);
    // Coordinate extremes.
    plan.push_back(mk_ray(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 0));
    plan.push_back(mk_tri(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, 0, 0));
    plan.push_back(mk_tri(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, -1, 1, 16'h8000, 1));
    plan.push_back(mk_ray(-1, 0, 1, CMIN, 1, -1, 1));
    foreach (plan[i]) send_beat(plan[i]);
    total = plan.size();

    // Random part over several floors; the second phase opens with a long
    // receiver hold, the third runs with no idling at all.
    floors = '{17'd0, 17'd65536, 17'($urandom_range(0, 65536)),
               rtch_pkg::MIN_DIST_RESET};
    for (int ph = 0; ph < 4; ph++) begin
      write_floor(floors[ph]);
      brisk = (ph == 2);
      hold_long = (ph == 1);
      while (total < 150 + ph * 135) begin
        if ($urandom_range(0, 9) == 0) begin
          b = mk_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
          b.command = $urandom_range(0, 1);
          send_beat(b);
          total++;
        end else begin
          send_search(sent);
          total += sent;
        end
      end
      send_beat(mk_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, 1));
      total++;
    end
    brisk = 0;
    in_valid = 0;

    wait (pending_hits.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0) begin
      $display("ray_triangle_closest_hit verification clean");
    end else begin
      $display("ray_triangle_closest_hit verification failed");
    end
    $finish;
  end

endmodule
